// ===== hdl/hds_pkg.sv =====
// Shared types and constants of the heat diffusion stencil step unit.
package hds_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 16;
  localparam int ROW_BITS      = 16;
  localparam int GW_BITS       = 13;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int NUM_JOBS      = 4;

  // Laplacian term, products and the accumulated sum in the arithmetic pipeline.
  localparam int LAP_BITS  = SAMPLE_BITS + 2;
  localparam int PROD_BITS = LAP_BITS + COEF_BITS + 1;
  localparam int ACC_BITS  = PROD_BITS + 1;

  localparam logic [GW_BITS-1:0]  GW_RESET = GW_BITS'(4096);
  localparam logic [ROW_BITS-1:0] GH_RESET = ROW_BITS'(4096);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COEF_BITS-1:0]          coef_t;
  typedef logic [ROW_BITS-1:0]           row_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_COEF_X      = 2'd2,
    CFG_COEF_Y      = 2'd3
  } cfg_idx_e;

  // Position of a sample inside the grid, as the window logic needs it.
  typedef struct packed {
    logic col_ge1;
    logic col_ge2;
    logic row_ge1;
    logic row_ge2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  // Operands of one five-point update.
  typedef struct packed {
    sample_t ctr;
    sample_t up;
    sample_t down;
    sample_t left;
    sample_t right;
  } stencil_ops_t;

endpackage

// ===== hdl/hds_if.sv =====
// Valid/ready channels for grid samples and for updated results.
interface hds_in_if;
  import hds_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hds_out_if #(
  parameter int COL_BITS = 12
);
  import hds_pkg::*;

  logic                valid;
  logic                ready;
  sample_t             new_value;
  logic [COL_BITS-1:0] column;
  row_t                row;
  logic                frame_end;

  modport source (output valid, output new_value, output column, output row,
                  output frame_end, input ready);
  modport sink   (input valid, input new_value, input column, input row,
                  input frame_end, output ready);
endinterface

// ===== hdl/heat_diffusion_stencil_step_unit.sv =====
// Top level of the heat diffusion stencil step unit: one explicit time step per grid pass.
//
// Grid samples enter in raster order on the sample_i channel, one request per
// grid point; updated values leave on result_o with their column, row and a
// frame_end flag on the very last point of the grid. An update is issued as
// soon as its right and lower neighbors have arrived, so during the last row
// the results of the last two rows come out interleaved by column.
// Grid size and the two diffusion coefficients must be written through the
// cfg_we_i / cfg_idx_i / cfg_data_i port while no request is in flight; the
// block does not enforce this. Throughput: one sample per cycle while each
// sample completes at most one result and the receiver does not stall; else the
// output port sets the pace at one result per cycle, as a row's last sample and
// a last-row sample complete up to two results and the grid's final sample up
// to four. The two row buffers are read and written once per sample at the
// sample's column. A result passes stage 1, the update queue and the three ALU
// stages. Reset clears the counters and all pipeline valid bits and restores
// the register defaults; the row buffers need no clearing, as an entry not yet
// written in the current frame is read but never used. When the receiver stalls,
// the result holds in the output register while the three pipeline stages and
// the update queue keep filling; sample_i.ready falls once they are full.
module heat_diffusion_stencil_step_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hds_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [hds_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  hds_in_if.sink                              sample_i,
  hds_out_if.source                           result_o
);
  import hds_pkg::*;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WCMP_BITS = (COL_BITS + 1 > GW_BITS) ? COL_BITS + 1 : GW_BITS;
  localparam logic [WCMP_BITS-1:0] WIDTH_LIMIT = WCMP_BITS'(MAX_WIDTH);

  // Configuration registers.
  logic [GW_BITS-1:0] gw_q;
  row_t               gh_q;
  coef_t              cx_q;
  coef_t              cy_q;

  // Raster position of the next request.
  logic [COL_BITS-1:0] col_q, col_d;
  row_t                row_q, row_d;

  // Stage holding a request while its row-buffer read completes.
  logic                s1_valid_q;
  sample_t             s1_x_q;
  logic [COL_BITS-1:0] s1_col_q;
  row_t                s1_row_q;
  pos_flags_t          s1_flags_q;

  logic [WCMP_BITS-1:0] w_eff;
  row_t                 h_eff;
  logic                 restart;
  logic [COL_BITS-1:0]  cur_col;
  row_t                 cur_row;
  pos_flags_t           cur_flags;
  logic                 accept;
  logic                 win_ready;
  logic                 s1_fire;

  sample_t newer;
  sample_t older;

  logic                job_valid;
  logic                job_ready;
  stencil_ops_t        job_ops;
  logic [COL_BITS-1:0] job_col;
  row_t                job_row;
  logic                job_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GW_RESET;
      gh_q <= GH_RESET;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  gw_q <= cfg_data_i[GW_BITS-1:0];
        CFG_GRID_HEIGHT: gh_q <= cfg_data_i[ROW_BITS-1:0];
        CFG_COEF_X:      cx_q <= cfg_data_i[COEF_BITS-1:0];
        CFG_COEF_Y:      cy_q <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A zero width or height acts as one; a width above the buffer depth is
  // limited to the buffer depth.
  always_comb begin
    if (gw_q == '0) begin
      w_eff = WCMP_BITS'(1);
    end else if (WCMP_BITS'(gw_q) > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT;
    end else begin
      w_eff = WCMP_BITS'(gw_q);
    end
    h_eff = (gh_q == '0) ? ROW_BITS'(1) : gh_q;
  end

  // If the grid was shrunk below the current position, the request starts a
  // new frame at the top left corner.
  always_comb begin
    restart            = (WCMP_BITS'(col_q) >= w_eff) || (row_q >= h_eff);
    cur_col            = restart ? '0 : col_q;
    cur_row            = restart ? '0 : row_q;
    cur_flags.col_ge1  = (cur_col != '0);
    cur_flags.col_ge2  = (cur_col > COL_BITS'(1));
    cur_flags.row_ge1  = (cur_row != '0);
    cur_flags.row_ge2  = (cur_row > ROW_BITS'(1));
    cur_flags.last_col = (WCMP_BITS'(cur_col) == w_eff - WCMP_BITS'(1));
    cur_flags.last_row = (cur_row == h_eff - ROW_BITS'(1));
    if (cur_flags.last_col) begin
      col_d = '0;
      row_d = cur_flags.last_row ? '0 : cur_row + ROW_BITS'(1);
    end else begin
      col_d = cur_col + COL_BITS'(1);
      row_d = cur_row;
    end
  end

  assign s1_fire        = s1_valid_q && win_ready;
  assign sample_i.ready = !s1_valid_q || win_ready;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= sample_i.sample;
      s1_col_q   <= cur_col;
      s1_row_q   <= cur_row;
      s1_flags_q <= cur_flags;
    end
  end

  // Read the column when the request arrives; write it back as it leaves stage 1.
  hds_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (cur_col),
    .wr_en_i    (s1_fire),
    .wr_addr_i  (s1_col_q),
    .wr_newer_i (s1_x_q),
    .newer_o    (newer),
    .older_o    (older)
  );

  hds_window #(
    .COL_BITS (COL_BITS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_fire),
    .load_ready_o (win_ready),
    .x_i          (s1_x_q),
    .col_i        (s1_col_q),
    .row_i        (s1_row_q),
    .flags_i      (s1_flags_q),
    .newer_i      (newer),
    .older_i      (older),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job_ops),
    .job_col_o    (job_col),
    .job_row_o    (job_row),
    .job_end_o    (job_end)
  );

  hds_stencil_alu #(
    .COL_BITS (COL_BITS)
  ) u_alu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_x_i    (cx_q),
    .coef_y_i    (cy_q),
    .in_valid_i  (job_valid),
    .in_ready_o  (job_ready),
    .ops_i       (job_ops),
    .col_i       (job_col),
    .row_i       (job_row),
    .end_i       (job_end),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .value_o     (result_o.new_value),
    .col_o       (result_o.column),
    .row_o       (result_o.row),
    .end_o       (result_o.frame_end)
  );

endmodule

// ===== hdl/hds_line_buf.sv =====
// Two row buffers in synchronous memories with write-to-read forwarding.
module hds_line_buf #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  hds_pkg::sample_t             wr_newer_i,
  output hds_pkg::sample_t             newer_o,
  output hds_pkg::sample_t             older_o
);
  import hds_pkg::*;

  sample_t mem_newer [MAX_WIDTH];
  sample_t mem_older [MAX_WIDTH];

  sample_t rd_newer_q;
  sample_t rd_older_q;
  sample_t last_newer_q;
  sample_t last_older_q;
  logic    fwd_q;

  // The entry moving to the older row is the one just read from the newer row.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_newer[wr_addr_i] <= wr_newer_i;
      mem_older[wr_addr_i] <= newer_o;
    end
    if (rd_en_i) begin
      rd_newer_q <= mem_newer[rd_addr_i];
      rd_older_q <= mem_older[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      last_newer_q <= wr_newer_i;
      last_older_q <= newer_o;
    end
  end

  // A read in the same cycle as a write to the same column sees stale data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign newer_o = fwd_q ? last_newer_q : rd_newer_q;
  assign older_o = fwd_q ? last_older_q : rd_older_q;

endmodule

// ===== hdl/hds_window.sv =====
// Sliding 3x3 neighborhood registers and the queue of pending updates.
module hds_window #(
  parameter int COL_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  output logic                  load_ready_o,
  input  hds_pkg::sample_t      x_i,
  input  logic [COL_BITS-1:0]   col_i,
  input  hds_pkg::row_t         row_i,
  input  hds_pkg::pos_flags_t   flags_i,
  input  hds_pkg::sample_t      newer_i,
  input  hds_pkg::sample_t      older_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output hds_pkg::stencil_ops_t job_o,
  output logic [COL_BITS-1:0]   job_col_o,
  output hds_pkg::row_t         job_row_o,
  output logic                  job_end_o
);
  import hds_pkg::*;

  localparam int SLOT_BITS = $clog2(NUM_JOBS);

  // Update slots in the order they leave the block.
  localparam int JOB_PREV_ROW  = 0;
  localparam int JOB_LAST_ROW  = 1;
  localparam int JOB_EDGE_PREV = 2;
  localparam int JOB_EDGE_LAST = 3;

  sample_t x1_q, x2_q, a1_q, a2_q, b1_q;

  stencil_ops_t        ops_q  [NUM_JOBS];
  logic [COL_BITS-1:0] jcol_q [NUM_JOBS];
  row_t                jrow_q [NUM_JOBS];
  logic [NUM_JOBS-1:0] mask_q, mask_d;

  stencil_ops_t        new_ops [NUM_JOBS];
  logic [COL_BITS-1:0] new_col [NUM_JOBS];
  row_t                new_row [NUM_JOBS];
  logic [NUM_JOBS-1:0] new_mask;

  logic [SLOT_BITS-1:0] sel;
  logic [NUM_JOBS-1:0]  sel_oh;
  logic [NUM_JOBS-1:0]  remaining;
  logic                 pop;
  logic [COL_BITS-1:0]  k;
  row_t                 rprev;

  // Names: x is the current row, a the row above, b two rows above;
  // suffix 1 is one column to the left, suffix 2 two columns.
  always_comb begin
    k     = col_i - COL_BITS'(1);
    rprev = row_i - ROW_BITS'(1);

    new_mask[JOB_PREV_ROW]      = flags_i.col_ge1 && flags_i.row_ge1;
    new_ops[JOB_PREV_ROW].ctr   = a1_q;
    new_ops[JOB_PREV_ROW].up    = flags_i.row_ge2 ? b1_q : a1_q;
    new_ops[JOB_PREV_ROW].down  = x1_q;
    new_ops[JOB_PREV_ROW].left  = flags_i.col_ge2 ? a2_q : a1_q;
    new_ops[JOB_PREV_ROW].right = newer_i;
    new_col[JOB_PREV_ROW]       = k;
    new_row[JOB_PREV_ROW]       = rprev;

    new_mask[JOB_LAST_ROW]      = flags_i.col_ge1 && flags_i.last_row;
    new_ops[JOB_LAST_ROW].ctr   = x1_q;
    new_ops[JOB_LAST_ROW].up    = flags_i.row_ge1 ? a1_q : x1_q;
    new_ops[JOB_LAST_ROW].down  = x1_q;
    new_ops[JOB_LAST_ROW].left  = flags_i.col_ge2 ? x2_q : x1_q;
    new_ops[JOB_LAST_ROW].right = x_i;
    new_col[JOB_LAST_ROW]       = k;
    new_row[JOB_LAST_ROW]       = row_i;

    new_mask[JOB_EDGE_PREV]      = flags_i.last_col && flags_i.row_ge1;
    new_ops[JOB_EDGE_PREV].ctr   = newer_i;
    new_ops[JOB_EDGE_PREV].up    = flags_i.row_ge2 ? older_i : newer_i;
    new_ops[JOB_EDGE_PREV].down  = x_i;
    new_ops[JOB_EDGE_PREV].left  = flags_i.col_ge1 ? a1_q : newer_i;
    new_ops[JOB_EDGE_PREV].right = newer_i;
    new_col[JOB_EDGE_PREV]       = col_i;
    new_row[JOB_EDGE_PREV]       = rprev;

    new_mask[JOB_EDGE_LAST]      = flags_i.last_col && flags_i.last_row;
    new_ops[JOB_EDGE_LAST].ctr   = x_i;
    new_ops[JOB_EDGE_LAST].up    = flags_i.row_ge1 ? newer_i : x_i;
    new_ops[JOB_EDGE_LAST].down  = x_i;
    new_ops[JOB_EDGE_LAST].left  = flags_i.col_ge1 ? x1_q : x_i;
    new_ops[JOB_EDGE_LAST].right = x_i;
    new_col[JOB_EDGE_LAST]       = col_i;
    new_row[JOB_EDGE_LAST]       = row_i;
  end

  always_comb begin
    sel = '0;
    for (int i = NUM_JOBS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SLOT_BITS'(i);
      end
    end
    sel_oh      = '0;
    sel_oh[sel] = 1'b1;
  end

  assign job_valid_o  = |mask_q;
  assign pop          = job_valid_o && job_ready_i;
  assign remaining    = mask_q & ~sel_oh;
  assign load_ready_o = (mask_q == '0) || (pop && (remaining == '0));
  assign mask_d       = load_i ? new_mask : (pop ? remaining : mask_q);

  assign job_o     = ops_q[sel];
  assign job_col_o = jcol_q[sel];
  assign job_row_o = jrow_q[sel];
  assign job_end_o = (sel == SLOT_BITS'(JOB_EDGE_LAST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x2_q <= x1_q;
      a2_q <= a1_q;
      x1_q <= x_i;
      a1_q <= newer_i;
      b1_q <= older_i;
      for (int i = 0; i < NUM_JOBS; i++) begin
        ops_q[i]  <= new_ops[i];
        jcol_q[i] <= new_col[i];
        jrow_q[i] <= new_row[i];
      end
    end
  end

endmodule

// ===== hdl/hds_stencil_alu.sv =====
// Three-stage arithmetic pipeline for one five-point update with saturation.
module hds_stencil_alu #(
  parameter int COL_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hds_pkg::coef_t        coef_x_i,
  input  hds_pkg::coef_t        coef_y_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hds_pkg::stencil_ops_t ops_i,
  input  logic [COL_BITS-1:0]   col_i,
  input  hds_pkg::row_t         row_i,
  input  logic                  end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hds_pkg::sample_t      value_o,
  output logic [COL_BITS-1:0]   col_o,
  output hds_pkg::row_t         row_o,
  output logic                  end_o
);
  import hds_pkg::*;

  localparam int Q_BITS = ACC_BITS - COEF_BITS;

  typedef logic signed [LAP_BITS-1:0]  lap_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;

  lap_t                ly1_q, lx1_q, ly_d, lx_d;
  sample_t             ctr1_q, ctr2_q;
  logic [COL_BITS-1:0] col1_q, col2_q, col3_q;
  row_t                row1_q, row2_q, row3_q;
  logic                end1_q, end2_q, end3_q;
  prod_t               py2_q, px2_q, py_d, px_d;
  sample_t             val3_q, val_d;

  acc_t                    acc;
  logic signed [Q_BITS-1:0] q;
  logic [Q_BITS-SAMPLE_BITS:0] q_top;

  assign r3         = !v3_q || out_ready_i;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  // Second differences along each axis.
  always_comb begin
    ly_d = LAP_BITS'(ops_i.up) + LAP_BITS'(ops_i.down) - (LAP_BITS'(ops_i.ctr) <<< 1);
    lx_d = LAP_BITS'(ops_i.left) + LAP_BITS'(ops_i.right) - (LAP_BITS'(ops_i.ctr) <<< 1);
  end

  assign py_d = $signed({1'b0, coef_y_i}) * ly1_q;
  assign px_d = $signed({1'b0, coef_x_i}) * lx1_q;

  // Adding the center scaled up before the shift gives floor(sum) + center.
  always_comb begin
    acc   = ACC_BITS'(py2_q) + ACC_BITS'(px2_q) + (ACC_BITS'(ctr2_q) <<< COEF_BITS);
    q     = $signed(acc[ACC_BITS-1:COEF_BITS]);
    q_top = q[Q_BITS-1:SAMPLE_BITS-1];
    if ((&q_top) || !(|q_top)) begin
      val_d = q[SAMPLE_BITS-1:0];
    end else if (q[Q_BITS-1]) begin
      val_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      val_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      ly1_q  <= ly_d;
      lx1_q  <= lx_d;
      ctr1_q <= ops_i.ctr;
      col1_q <= col_i;
      row1_q <= row_i;
      end1_q <= end_i;
    end
    if (r2 && v1_q) begin
      py2_q  <= py_d;
      px2_q  <= px_d;
      ctr2_q <= ctr1_q;
      col2_q <= col1_q;
      row2_q <= row1_q;
      end2_q <= end1_q;
    end
    if (r3 && v2_q) begin
      val3_q <= val_d;
      col3_q <= col2_q;
      row3_q <= row2_q;
      end3_q <= end2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign value_o     = val3_q;
  assign col_o       = col3_q;
  assign row_o       = row3_q;
  assign end_o       = end3_q;

endmodule

// ===== hdl/hds_checker.sv =====
// Port-level checks of the heat diffusion stencil step unit and their binding.
module hds_checker #(
  parameter int MAX_WIDTH = 4096
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [hds_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input logic [hds_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input hds_pkg::sample_t                   new_value_i,
  input logic [$clog2(MAX_WIDTH)-1:0]       column_i,
  input hds_pkg::row_t                      row_i,
  input logic                               frame_end_i
);
  import hds_pkg::*;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WCMP_BITS = (COL_BITS + 1 > GW_BITS) ? COL_BITS + 1 : GW_BITS;
  localparam logic [WCMP_BITS-1:0] WIDTH_LIMIT = WCMP_BITS'(MAX_WIDTH);

  logic [GW_BITS-1:0]   gw_q;
  row_t                 gh_q;
  logic                 seen_q;
  logic [WCMP_BITS-1:0] w_eff;
  row_t                 h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= GW_RESET;
      gh_q   <= GH_RESET;
      seen_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_GRID_WIDTH)) gw_q <= cfg_data_i[GW_BITS-1:0];
      if (cfg_we_i && (cfg_idx_i == CFG_GRID_HEIGHT)) gh_q <= cfg_data_i[ROW_BITS-1:0];
      if (in_valid_i && in_ready_i) seen_q <= 1'b1;
    end
  end

  always_comb begin
    if (gw_q == '0) begin
      w_eff = WCMP_BITS'(1);
    end else if (WCMP_BITS'(gw_q) > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT;
    end else begin
      w_eff = WCMP_BITS'(gw_q);
    end
    h_eff = (gh_q == '0) ? ROW_BITS'(1) : gh_q;
  end

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(new_value_i) &&
      $stable(column_i) && $stable(row_i) && $stable(frame_end_i))
    else $error("result changed while stalled");

  // Every result lies inside the configured grid.
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (WCMP_BITS'(column_i) < w_eff) && (row_i < h_eff))
    else $error("result position outside the grid");

  // The end-of-grid flag marks the bottom right corner only.
  a_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |->
      (WCMP_BITS'(column_i) == w_eff - WCMP_BITS'(1)) && (row_i == h_eff - ROW_BITS'(1)))
    else $error("frame end away from the last grid point");

  // No result before the first request.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q)
    else $error("result without any request");

endmodule

bind heat_diffusion_stencil_step_unit hds_checker #(
  .MAX_WIDTH (MAX_WIDTH)
) u_hds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .new_value_i (result_o.new_value),
  .column_i    (result_o.column),
  .row_i       (result_o.row),
  .frame_end_i (result_o.frame_end)
);
